@@ rtl/core/dpds_pkg.sv @@
// Shared types and constants for the debounced PWM duty stepper.
package dpds_pkg;

  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PROD_W  = DUTY_W + PERIOD_W;
  localparam int unsigned RECIP_W = 24;
  localparam int unsigned QUOT_W  = PROD_W + RECIP_W;

  localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd100;
  localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd60;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;
  localparam logic [COUNT_W-1:0]  THRESH_RESET = 8'd10;
  localparam logic [DUTY_W-1:0]   STEP_RESET   = 7'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;

  // ceil(2^30 / 100): exact floor(x / 100) for every x below 100 * 2^16
  localparam logic [RECIP_W-1:0] RECIP_100   = 24'd10737419;
  localparam int unsigned        RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_INC  = 2'd1,
    MODE_DEC  = 2'd2
  } dpds_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_STEP      = 2'd1,
    CFG_PERIOD    = 2'd2
  } dpds_cfg_idx_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } dpds_cfg_wr_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              step_up;
    logic              changed;
  } dpds_result_t;

endpackage

@@ rtl/core/dpds_if.sv @@
// Valid/ready channel interfaces for input words, result words and config writes.
interface dpds_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic                          button_level;
  logic [dpds_pkg::DUTY_W-1:0]   step_amount;

  modport source (output valid, mode, button_level, step_amount, input ready);
  modport sink   (input valid, mode, button_level, step_amount, output ready);
endinterface

interface dpds_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpds_pkg::DUTY_W-1:0]   duty_percent;
  logic [dpds_pkg::PERIOD_W-1:0] compare_value;
  logic                          direction_up;
  logic                          duty_changed;

  modport source (output valid, duty_percent, compare_value, direction_up, duty_changed,
                  input ready);
  modport sink   (input valid, duty_percent, compare_value, direction_up, duty_changed,
                  output ready);
endinterface

interface dpds_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpds_pkg::CFG_IDX_W-1:0]  index;
  logic [dpds_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/debounced_pwm_duty_stepper.sv @@
// Top level of the debounced PWM duty stepper.
//
//  channel | dir | handshake       | word
//  --------+-----+-----------------+-------------------------------------------------
//  in_ch   | in  | valid / ready   | mode, button_level, step_amount
//  out_ch  | out | valid / ready   | duty_percent, compare_value, direction_up,
//          |     |                 | duty_changed
//  cfg_ch  | in  | valid / ready=1 | index (0 threshold, 1 button step, 2 period), data
//
// One word is taken per cycle unless the pipeline is full and its output stalled; its result is
// registered through capture, period multiply and reciprocal divide by 100, one result per word.
// Debounce, duty and direction state update in the cycle a word is accepted.
// rst_n is synchronous, active low: duty 60, direction up, disarmed, count 0,
// config to threshold 10, step 10, period 65535.
// A stalled output holds its word; input stays ready while any pipeline stage is free or the output word is taken.
module debounced_pwm_duty_stepper (
  input  logic               clk,
  input  logic               rst_n,
  dpds_in_if.sink            in_ch,
  dpds_out_if.source         out_ch,
  dpds_cfg_if.sink           cfg_ch
);

  logic                          accept;
  logic                          pipe_ready;
  dpds_pkg::dpds_cfg_wr_t        cfg_wr;
  dpds_pkg::dpds_result_t        step_res;
  dpds_pkg::dpds_result_t        out_res;
  logic [dpds_pkg::PERIOD_W-1:0] period;
  logic [dpds_pkg::PERIOD_W-1:0] out_compare;

  // Config writes are always taken; unknown indexes drop.
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.we    = cfg_ch.valid;
  assign cfg_wr.index = cfg_ch.index;
  assign cfg_wr.data  = cfg_ch.data;

  assign in_ch.ready = pipe_ready;
  assign accept      = in_ch.valid && pipe_ready;

  // Advance debounce and duty state on each accepted word.
  dpds_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .mode   (in_ch.mode),
    .level  (in_ch.button_level),
    .amount (in_ch.step_amount),
    .cfg_wr (cfg_wr),
    .result (step_res),
    .period (period)
  );

  // Carry the post-update duty through the compare-value pipeline.
  dpds_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (pipe_ready),
    .in_res      (step_res),
    .period      (period),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_res     (out_res),
    .out_compare (out_compare)
  );

  assign out_ch.duty_percent  = out_res.duty;
  assign out_ch.direction_up  = out_res.step_up;
  assign out_ch.duty_changed  = out_res.changed;
  assign out_ch.compare_value = out_compare;

endmodule

@@ rtl/core/dpds_ctrl.sv @@
// Config registers, debounce integrator and duty/direction state update.
module dpds_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [1:0]                     mode,
  input  logic                           level,
  input  logic [dpds_pkg::DUTY_W-1:0]    amount,
  input  dpds_pkg::dpds_cfg_wr_t         cfg_wr,
  output dpds_pkg::dpds_result_t         result,
  output logic [dpds_pkg::PERIOD_W-1:0]  period
);

  logic [dpds_pkg::COUNT_W-1:0]  thresh_r;
  logic [dpds_pkg::DUTY_W-1:0]   bstep_r;
  logic [dpds_pkg::PERIOD_W-1:0] period_r;

  logic                          armed_r, armed_nxt;
  logic [dpds_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [dpds_pkg::DUTY_W-1:0]   duty_r, duty_nxt;
  logic                          up_r, up_nxt;

  logic                          do_step;
  logic                          step_dir;
  logic [dpds_pkg::DUTY_W-1:0]   step_amt;
  logic [dpds_pkg::DUTY_W:0]     sum;
  logic [dpds_pkg::DUTY_W-1:0]   stepped;
  logic                          armed_t;
  logic [dpds_pkg::COUNT_W-1:0]  count_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= dpds_pkg::THRESH_RESET;
      bstep_r  <= dpds_pkg::STEP_RESET;
      period_r <= dpds_pkg::PERIOD_RESET;
    end else if (cfg_wr.we) begin
      unique case (dpds_pkg::dpds_cfg_idx_t'(cfg_wr.index))
        dpds_pkg::CFG_THRESHOLD: thresh_r <= cfg_wr.data[dpds_pkg::COUNT_W-1:0];
        dpds_pkg::CFG_STEP:      bstep_r  <= cfg_wr.data[dpds_pkg::DUTY_W-1:0];
        dpds_pkg::CFG_PERIOD:    period_r <= cfg_wr.data[dpds_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick path: arm on a high sample, then integrate (low adds, high removes).
  always_comb begin
    armed_t = armed_r | level;
    count_t = count_r;
    if (armed_t) begin
      if (!level) begin
        if (count_r != dpds_pkg::COUNT_MAX) count_t = count_r + 8'd1;
      end else if (count_r != '0) begin
        count_t = count_r - 8'd1;
      end
    end
  end

  always_comb begin
    armed_nxt = armed_r;
    count_nxt = count_r;
    do_step   = 1'b0;
    step_dir  = up_r;
    step_amt  = bstep_r;
    unique case (dpds_pkg::dpds_mode_t'(mode))
      dpds_pkg::MODE_TICK: begin
        if (count_t > thresh_r) begin
          armed_nxt = 1'b0;
          count_nxt = '0;
          do_step   = 1'b1;
        end else begin
          armed_nxt = armed_t;
          count_nxt = count_t;
        end
      end
      dpds_pkg::MODE_INC: begin
        do_step  = 1'b1;
        step_dir = 1'b1;
        step_amt = amount;
      end
      dpds_pkg::MODE_DEC: begin
        do_step  = 1'b1;
        step_dir = 1'b0;
        step_amt = amount;
      end
      default: ;
    endcase

    // Saturate the duty to 0..100.
    sum = {1'b0, duty_r} + {1'b0, step_amt};
    if (step_dir) begin
      stepped = (sum > {1'b0, dpds_pkg::DUTY_MAX}) ? dpds_pkg::DUTY_MAX
                                                   : sum[dpds_pkg::DUTY_W-1:0];
    end else begin
      stepped = (step_amt >= duty_r) ? '0 : duty_r - step_amt;
    end

    duty_nxt = duty_r;
    up_nxt   = up_r;
    if (do_step) begin
      duty_nxt = stepped;
      if (stepped == '0) begin
        up_nxt = 1'b1;
      end else if (stepped >= dpds_pkg::DUTY_MAX) begin
        up_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      count_r <= '0;
      duty_r  <= dpds_pkg::DUTY_RESET;
      up_r    <= 1'b1;
    end else if (accept) begin
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      duty_r  <= duty_nxt;
      up_r    <= up_nxt;
    end
  end

  assign result.duty    = duty_nxt;
  assign result.step_up = up_nxt;
  assign result.changed = do_step;
  assign period         = period_r;

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= dpds_pkg::DUTY_MAX)
    else $error("duty left 0..100");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> count_r == '0)
    else $error("debounce count nonzero while disarmed");

  a_dir_floor: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r == '0 |-> up_r)
    else $error("direction not up at zero duty");

  a_dir_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r == dpds_pkg::DUTY_MAX |-> !up_r)
    else $error("direction not down at full duty");

endmodule

@@ rtl/core/dpds_scale.sv @@
// Three-stage pipeline: capture result, multiply by period, divide by 100.
module dpds_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dpds_pkg::dpds_result_t         in_res,
  input  logic [dpds_pkg::PERIOD_W-1:0]  period,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dpds_pkg::dpds_result_t         out_res,
  output logic [dpds_pkg::PERIOD_W-1:0]  out_compare
);

  logic                         v1_r, v2_r, v3_r;
  logic                         rdy1, rdy2, rdy3;
  dpds_pkg::dpds_result_t       res1_r, res2_r, res3_r;
  logic [dpds_pkg::PROD_W-1:0]  prod2_r, prod_nxt;
  logic [dpds_pkg::QUOT_W-1:0]  quot;
  logic [dpds_pkg::PERIOD_W-1:0] cmp3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign prod_nxt = dpds_pkg::PROD_W'(res1_r.duty) * dpds_pkg::PROD_W'(period);
  assign quot     = dpds_pkg::QUOT_W'(prod2_r) * dpds_pkg::QUOT_W'(dpds_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) res1_r <= in_res;
    if (rdy2 && v1_r) begin
      res2_r  <= res1_r;
      prod2_r <= prod_nxt;
    end
    if (rdy3 && v2_r) begin
      res3_r <= res2_r;
      cmp3_r <= quot[dpds_pkg::RECIP_SHIFT +: dpds_pkg::PERIOD_W];
    end
  end

  assign out_valid   = v3_r;
  assign out_res     = res3_r;
  assign out_compare = cmp3_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ready |=> v3_r)
    else $error("result word dropped while stalled");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && rdy3 |=> v3_r)
    else $error("stage two word did not advance");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && !out_ready |-> !in_ready)
    else $error("input accepted into full pipeline");

endmodule

@@ dv/tb.sv @@
// Self-checking bench for the debounced PWM duty stepper: directed and random words.
`timescale 1ns / 1ps

module tb;
  import dpds_pkg::*;

  // Mode code with no operation behind it, and a register index with no register.
  localparam logic [1:0]           MODE_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned PRESSURE_AT     = 300;
  localparam int unsigned PRESSURE_CYCLES = 200;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] compare;
    logic                up;
    logic                changed;
  } duty_word_t;

  // Tracks debounce, duty and direction state and queues the result word due
  // for every accepted input word.
  class duty_tracker;
    logic [COUNT_W-1:0]  thresh;
    logic [DUTY_W-1:0]   step;
    logic [PERIOD_W-1:0] period;
    bit                  armed;
    logic [COUNT_W-1:0]  count;
    logic [DUTY_W-1:0]   duty;
    bit                  step_up;
    duty_word_t          pending_duty[$];
    int unsigned         errors;

    function new();
      thresh  = THRESH_RESET;
      step    = STEP_RESET;
      period  = PERIOD_RESET;
      armed   = 1'b0;
      count   = '0;
      duty    = DUTY_RESET;
      step_up = 1'b1;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_THRESHOLD: thresh = value[COUNT_W-1:0];
        CFG_STEP:      step   = value[DUTY_W-1:0];
        CFG_PERIOD:    period = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Saturate to 0..100, then turn the ping-pong flag at either end.
    function void step_duty(bit up, logic [DUTY_W-1:0] amt);
      int unsigned d;
      d = duty;
      if (up) begin
        d = d + amt;
        if (d > 100) d = 100;
      end else begin
        d = (amt >= d) ? 0 : d - amt;
      end
      duty = d[DUTY_W-1:0];
      if (duty == 0) step_up = 1'b1;
      else if (duty >= DUTY_MAX) step_up = 1'b0;
    endfunction

    function void take_word(logic [1:0] mode, logic level, logic [DUTY_W-1:0] amt);
      duty_word_t  w;
      bit          changed;
      int unsigned prod;
      changed = 1'b0;
      case (mode)
        MODE_TICK: begin
          // Arm first; the arming tick counts too.
          if (level) armed = 1'b1;
          if (armed) begin
            if (!level) begin
              if (count != COUNT_MAX) count++;
            end else if (count != 0) begin
              count--;
            end
          end
          if (count > thresh) begin
            armed = 1'b0;
            count = '0;
            step_duty(step_up, step);
            changed = 1'b1;
          end
        end
        MODE_INC: begin
          step_duty(1'b1, amt);
          changed = 1'b1;
        end
        MODE_DEC: begin
          step_duty(1'b0, amt);
          changed = 1'b1;
        end
        default: ;
      endcase
      prod      = duty * period;
      w.duty    = duty;
      w.compare = PERIOD_W'(prod / 100);
      w.up      = step_up;
      w.changed = changed;
      pending_duty.push_back(w);
    endfunction

    function void check_duty_word(logic [DUTY_W-1:0] d, logic [PERIOD_W-1:0] c,
                                  logic up, logic ch);
      duty_word_t w;
      if (pending_duty.size() == 0) begin
        $display("%0t: result word with none pending: duty %0d compare %0d up %0d changed %0d",
                 $time, d, c, up, ch);
        errors++;
        return;
      end
      w = pending_duty.pop_front();
      if (d !== w.duty) begin
        $display("%0t: duty_percent expected %0d got %0d", $time, w.duty, d);
        errors++;
      end
      if (c !== w.compare) begin
        $display("%0t: compare_value expected %0d got %0d", $time, w.compare, c);
        errors++;
      end
      if (up !== w.up) begin
        $display("%0t: direction_up expected %0d got %0d", $time, w.up, up);
        errors++;
      end
      if (ch !== w.changed) begin
        $display("%0t: duty_changed expected %0d got %0d", $time, w.changed, ch);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dpds_in_if  in_ch();
  dpds_out_if out_ch();
  dpds_cfg_if cfg_ch();

  debounced_pwm_duty_stepper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  duty_tracker tracker;
  bit          no_gaps;
  int unsigned words_in;
  int unsigned cycle_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Amounts: mostly small so the duty wanders, sometimes anywhere up to 127.
  function automatic logic [DUTY_W-1:0] pick_amount();
    if ($urandom_range(0, 3) == 0) return DUTY_W'($urandom_range(0, 127));
    return DUTY_W'($urandom_range(0, 30));
  endfunction

  // Offer one input word and hold it until the block takes it. Valid stays
  // high into the next word when there is no gap, so it is never dropped and
  // raised in the same step.
  task automatic send_word(logic [1:0] mode, logic level, logic [DUTY_W-1:0] amt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.button_level <= level;
    in_ch.step_amount  <= amt;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tracker.take_word(mode, level, amt);
    words_in++;
  endtask

  // Drop valid, let every pending result drain, then let the pipeline settle
  // before touching the registers.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_duty.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers plus the unused index. Upper data bits beyond
  // each register's width are random and must be dropped by the block.
  task automatic program_regs(logic [COUNT_W-1:0] thr, logic [DUTY_W-1:0] stp,
                              logic [PERIOD_W-1:0] per);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx[0] = CFG_THRESHOLD;
    val[0] = {8'($urandom), thr};
    idx[1] = CFG_STEP;
    val[1] = {9'($urandom), stp};
    idx[2] = CFG_PERIOD;
    val[2] = per;
    idx[3] = CFG_UNUSED;
    val[3] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic. Most of it is whole presses: a high tick to arm, then
  // mostly low ticks with some bounce until the press is taken (or a cap,
  // which is what drives the counter into saturation at the top threshold).
  // The rest is commands, loose ticks and the unused mode.
  task automatic run_phase(int unsigned quota);
    int unsigned start, kind, n, cap;
    start = words_in;
    while (words_in - start < quota) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        send_word(MODE_TICK, 1'b1, DUTY_W'($urandom_range(0, 127)));
        n   = 0;
        cap = 2 * tracker.thresh + 20;
        while (tracker.armed && n < cap) begin
          send_word(MODE_TICK, $urandom_range(0, 9) == 0, DUTY_W'($urandom_range(0, 127)));
          n++;
        end
      end else if (kind < 8) begin
        send_word($urandom_range(0, 1) ? MODE_INC : MODE_DEC, 1'($urandom_range(0, 1)),
                  pick_amount());
      end else if (kind == 8) begin
        send_word(MODE_TICK, 1'($urandom_range(0, 1)), DUTY_W'($urandom_range(0, 127)));
      end else begin
        send_word(MODE_NONE, 1'($urandom_range(0, 1)), DUTY_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // Result side: check every accepted word, then pick ready for the next
  // edge. Once enough words are in, hold ready low for a long stretch so the
  // pipeline fills and the block has to stall its input.
  initial begin
    int unsigned stall_left;
    bit          pressure_done;
    stall_left    = 0;
    pressure_done = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tracker.check_duty_word(out_ch.duty_percent, out_ch.compare_value,
                                out_ch.direction_up, out_ch.duty_changed);
      if (!pressure_done && words_in >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_CYCLES;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0]  thr;
    logic [DUTY_W-1:0]   stp;
    logic [PERIOD_W-1:0] per;
    int unsigned         quota;

    tracker            = new();
    words_in           = 0;
    no_gaps            = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.button_level = 1'b0;
    in_ch.step_amount  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_THRESHOLD;
    cfg_ch.data        = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings (threshold 10, step 10, period top).
    // Saturate up past 100 and flip direction down.
    send_word(MODE_INC, 1'b0, 7'd127);
    // Zero amount still counts as a step.
    send_word(MODE_INC, 1'b1, 7'd0);
    // Saturate down past 0 and flip direction up.
    send_word(MODE_DEC, 1'b0, 7'd127);
    send_word(MODE_DEC, 1'b1, 7'd0);
    send_word(MODE_INC, 1'b0, 7'd100);
    send_word(MODE_DEC, 1'b0, 7'd1);
    // Unused mode changes nothing.
    send_word(MODE_NONE, 1'b1, 7'd127);
    // Low tick while disarmed is ignored; high tick arms.
    send_word(MODE_TICK, 1'b0, 7'd0);
    send_word(MODE_TICK, 1'b1, 7'd0);
    // Eleven lows pass threshold 10 and step the duty down.
    repeat (11) send_word(MODE_TICK, 1'b0, 7'd0);
    // Rearm, then a command while armed leaves the counter alone.
    send_word(MODE_TICK, 1'b1, 7'd0);
    send_word(MODE_INC, 1'b0, 7'd5);
    send_word(MODE_TICK, 1'b0, 7'd0);
    // Count back to zero and hold there on further highs.
    send_word(MODE_TICK, 1'b1, 7'd0);
    send_word(MODE_TICK, 1'b1, 7'd0);

    // Random phases: extremes first (threshold 0, 254 and 255, where at 255 no press
    // is ever taken; step 1, 100, 127 and 0; period 1, 65535 and 0), then
    // random settings. Two phases draw no random idle gaps on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      quota = 150;
      case (p)
        0: begin thr = 8'd0;   stp = 7'd1;   per = 16'd1;     end
        1: begin thr = 8'd3;   stp = 7'd100; per = 16'hFFFF;  end
        2: begin thr = 8'd254; stp = 7'd127; per = 16'd0;     quota = 100; end
        3: begin thr = 8'd255; stp = 7'd0;   per = 16'd12345; quota = 100; end
        default: begin
          thr = COUNT_W'($urandom_range(0, 20));
          stp = DUTY_W'($urandom_range(0, 127));
          per = PERIOD_W'($urandom);
        end
      endcase
      wait_idle();
      program_regs(thr, stp, per);
      no_gaps = (p == 1 || p == 4);
      run_phase(quota);
    end

    wait_idle();
    if (tracker.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
